// File: design/mcvs_pkg.sv
`timescale 1ns / 1ps

package mcvs_pkg;

  // Input selector codes (carried in tuser)
  localparam logic [1:0] MODE_EVENT  = 2'd0;
  localparam logic [1:0] MODE_MASTER = 2'd1;
  localparam logic [1:0] MODE_RESET  = 2'd2;

  // MIDI codes
  localparam logic [3:0] CTRL_NIBBLE   = 4'hB;
  localparam logic [7:0] VOLUME_CC     = 8'h07;
  localparam logic [6:0] DEFAULT_LEVEL = 7'd100;
  localparam logic [6:0] VOLUME_MAX    = 7'd127;

  // floor(p / 100) for p < 2**14 as (p * RECIP) >> RECIP_SHIFT
  localparam int          RECIP_SHIFT = 21;
  localparam logic [14:0] RECIP       = 15'd20972;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_t;

endpackage

// File: design/midi_channel_volume_scaler.sv
`timescale 1ns / 1ps

// MIDI channel volume scaler. Each input item carries a mode in s_tuser.
// Mode 0 passes an event word and its delta through; a main-volume controller
// has its volume stored for its channel and rewritten as volume*percent/100,
// saturated to 127. Mode 1 sets the master percent and emits one direct
// main-volume message per channel, channel 0 first, tlast on the final one.
// Mode 2 sets all stored channel volumes back to 100; mode 3 is ignored.
// One shared two-step multiply unit does all scaling; a stream event passes
// through ST_MUL and ST_DIV before s_tready returns, a master update repeats
// them once per channel, and modes 2 and 3 leave s_tready high; a stalled output
// register holds the sequencer until m_tready frees it.
module midi_channel_volume_scaler #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // event_word[31:0], delta_ticks[63:32], new_volume[70:64]
  input  logic [1:0]  s_tuser,  // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // out_word[31:0], out_delta[63:32]
  output logic        m_tuser,  // direct[0]
  output logic        m_tlast
);
  import mcvs_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state, state_next;

  logic [6:0]      channel_volumes [CHANNELS];
  logic [6:0]      master_percent;
  logic [31:0]     word;
  logic [31:0]     delta;
  logic [6:0]      vol;
  logic            is_cc;
  logic            is_update;
  logic [CH_W-1:0] ch;

  logic            accept;
  logic            out_free;
  logic            mul_en;
  logic            out_load;
  logic            ch_last;
  logic [6:0]      mul_vol;
  logic [6:0]      scaled;

  logic [31:0]     in_word;
  logic [3:0]      in_ch;
  logic            in_cc;
  logic            in_store;

  // input field decode
  always_comb begin
    in_word  = s_tdata[31:0];
    in_ch    = in_word[3:0];
    in_cc    = (in_word[7:4] == CTRL_NIBBLE) && (in_word[15:8] == VOLUME_CC);
    in_store = ({1'b0, in_ch} < 5'(CHANNELS));
  end

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign ch_last  = (ch == CH_W'(CHANNELS - 1));
  assign mul_vol  = is_update ? channel_volumes[ch] : vol;

  mcvs_scale_unit u_scale (
    .clk    (clk),
    .mul_en (mul_en),
    .vol    (mul_vol),
    .pct    (master_percent),
    .scaled (scaled)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (s_tuser == MODE_EVENT || s_tuser == MODE_MASTER)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (out_free) begin
          state_next = (is_update && !ch_last) ? ST_MUL : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = (state == ST_IDLE);
    mul_en   = (state == ST_MUL);
    out_load = (state == ST_DIV) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stored volumes and master percent
  always_ff @(posedge clk) begin
    if (rst) begin
      master_percent <= DEFAULT_LEVEL;
      for (int i = 0; i < CHANNELS; i++) begin
        channel_volumes[i] <= DEFAULT_LEVEL;
      end
    end else if (accept) begin
      unique case (s_tuser)
        MODE_EVENT: begin
          if (in_cc && in_store) begin
            channel_volumes[in_ch[CH_W-1:0]] <= in_word[22:16];
          end
        end
        MODE_MASTER: master_percent <= s_tdata[70:64];
        MODE_RESET: begin
          for (int i = 0; i < CHANNELS; i++) begin
            channel_volumes[i] <= DEFAULT_LEVEL;
          end
        end
        default: ;
      endcase
    end
  end

  // captured item and channel counter
  always_ff @(posedge clk) begin
    if (accept) begin
      word      <= in_word;
      delta     <= s_tdata[63:32];
      vol       <= in_word[22:16];
      is_cc     <= in_cc;
      is_update <= (s_tuser == MODE_MASTER);
      ch        <= '0;
    end else if (out_load && is_update && !ch_last) begin
      ch <= ch + CH_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (is_update) begin
        m_tdata <= {32'd0, 8'h00, 1'b0, scaled, VOLUME_CC, CTRL_NIBBLE, 4'(ch)};
        m_tuser <= 1'b1;
        m_tlast <= ch_last;
      end else begin
        m_tdata[63:32] <= delta;
        m_tdata[31:0]  <= is_cc ? {word[31:24], 1'b0, scaled, word[15:0]} : word;
        m_tuser        <= 1'b0;
        m_tlast        <= 1'b1;
      end
    end
  end

endmodule

// File: design/mcvs_scale_unit.sv
`timescale 1ns / 1ps

// Shared scaler: volume * percent registered, then divide by 100 through a
// reciprocal multiply and saturate to 127.
module mcvs_scale_unit (
  input  logic       clk,
  input  logic       mul_en,
  input  logic [6:0] vol,
  input  logic [6:0] pct,
  output logic [6:0] scaled
);
  import mcvs_pkg::*;

  logic [13:0] prod;
  logic [28:0] recip_prod;
  logic [7:0]  quot;

  // first step: 7x7 product
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= 14'(vol) * 14'(pct);
    end
  end

  // second step: divide by constant 100, clamp
  always_comb begin
    recip_prod = 29'(prod) * 29'(RECIP);
    quot       = recip_prod[RECIP_SHIFT +: 8];
    scaled     = (quot > 8'(VOLUME_MAX)) ? VOLUME_MAX : quot[6:0];
  end

endmodule
